// ===== hdl/tfn_pkg.sv =====
package tfn_pkg;

    // Field widths
    localparam int CoordW = 24;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int MagW   = 50;
    localparam int HalfW  = MagW / 2;
    localparam int SqW    = 2 * MagW;
    localparam int RootW  = 51;
    localparam int RemW   = SqW + 3;
    localparam int FracW  = 14;
    localparam int QuotW  = FracW + 1;
    localparam int DivW   = RootW + FracW + 1;
    localparam int NormW  = 16;
    localparam int LimW   = 50;

    localparam logic [NormW-1:0] OneQ14 = NormW'(16384);
    localparam logic [LimW-1:0]  LimitReset = LimW'(1);

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } tfn_vec_t;

    typedef struct packed {
        logic signed [DiffW-1:0] x;
        logic signed [DiffW-1:0] y;
        logic signed [DiffW-1:0] z;
    } tfn_dvec_t;

    // Sign of each cross component and the all-zero flag
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } tfn_side_t;

    typedef logic [2:0][MagW-1:0] tfn_mag3_t;

endpackage

// ===== hdl/triangle_face_normal.sv =====
// Channel  | Direction | Handshake              | Payload
// s_       | in        | s_valid / s_ready      | s_p0_x .. s_p2_z, 24 bit signed Q12.12
// m_       | out       | m_valid / m_ready      | m_normal_x/y/z Q1.14, m_degenerate
// cfg_     | in        | cfg_valid / cfg_ready  | cfg_twice_area_limit, 50 bit
//
// One item per cycle while the output does not stall. Stages: the cross product, the
// squared length, the root (one bit a stage), the divide (one quotient bit a
// stage) and one output register.
// Reset clears every valid bit and sets the limit to 1.
// A stall at the output freezes the whole pipeline; s_ready drops only then.
module triangle_face_normal (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p0_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p0_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p0_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p1_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p1_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p1_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p2_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p2_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   s_p2_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tfn_pkg::NormW-1:0]    m_normal_x,
    output logic signed [tfn_pkg::NormW-1:0]    m_normal_y,
    output logic signed [tfn_pkg::NormW-1:0]    m_normal_z,
    output logic                                m_degenerate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tfn_pkg::LimW-1:0]            cfg_twice_area_limit
);

    logic en;
    logic [tfn_pkg::LimW-1:0] limit_reg;
    tfn_pkg::tfn_vec_t p0, p1, p2;

    logic                        cr_valid, sq_valid, rt_valid;
    tfn_pkg::tfn_mag3_t          cr_mag, sq_mag, rt_mag;
    tfn_pkg::tfn_side_t          cr_side, sq_side, rt_side;
    logic [tfn_pkg::SqW-1:0]     sq_sum;
    logic [tfn_pkg::RootW-1:0]   rt_len;

    // Advance whenever the output register is free or being emptied
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Hold the area limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= tfn_pkg::LimitReset;
        end else if (cfg_valid) begin
            limit_reg <= cfg_twice_area_limit;
        end
    end

    assign p0 = '{x: s_p0_x, y: s_p0_y, z: s_p0_z};
    assign p1 = '{x: s_p1_x, y: s_p1_y, z: s_p1_z};
    assign p2 = '{x: s_p2_x, y: s_p2_y, z: s_p2_z};

    tfn_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .p0        (p0),
        .p1        (p1),
        .p2        (p2),
        .out_valid (cr_valid),
        .out_mag   (cr_mag),
        .out_side  (cr_side)
    );

    tfn_sqsum u_sqsum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cr_valid),
        .in_mag    (cr_mag),
        .in_side   (cr_side),
        .out_valid (sq_valid),
        .out_sum   (sq_sum),
        .out_mag   (sq_mag),
        .out_side  (sq_side)
    );

    tfn_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_sum    (sq_sum),
        .in_mag    (sq_mag),
        .in_side   (sq_side),
        .out_valid (rt_valid),
        .out_len   (rt_len),
        .out_mag   (rt_mag),
        .out_side  (rt_side)
    );

    tfn_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (rt_valid),
        .in_len         (rt_len),
        .in_mag         (rt_mag),
        .in_side        (rt_side),
        .limit          (limit_reg),
        .out_valid      (m_valid),
        .out_x          (m_normal_x),
        .out_y          (m_normal_y),
        .out_z          (m_normal_z),
        .out_degenerate (m_degenerate)
    );

    // Normal components never exceed one in magnitude
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x <= 16'sd16384) && (m_normal_x >= -16'sd16384)
                 && (m_normal_y <= 16'sd16384) && (m_normal_y >= -16'sd16384)
                 && (m_normal_z <= 16'sd16384) && (m_normal_z >= -16'sd16384))
        else $error("normal component out of range");

    // A configuration write lands in the limit register
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> limit_reg == $past(cfg_twice_area_limit))
        else $error("limit write lost");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== hdl/tfn_cross.sv =====
module tfn_cross (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  tfn_pkg::tfn_vec_t     p0,
    input  tfn_pkg::tfn_vec_t     p1,
    input  tfn_pkg::tfn_vec_t     p2,
    output logic                  out_valid,
    output tfn_pkg::tfn_mag3_t    out_mag,
    output tfn_pkg::tfn_side_t    out_side
);

    tfn_pkg::tfn_dvec_t a_reg, a_next, b_reg, b_next;
    logic signed [tfn_pkg::ProdW-1:0] prod_reg [6];
    logic signed [tfn_pkg::ProdW-1:0] prod_next [6];
    tfn_pkg::tfn_mag3_t mag_reg, mag_next;
    tfn_pkg::tfn_side_t side_reg, side_next;
    logic [2:0] vld_reg;
    logic signed [tfn_pkg::ProdW:0] c [3];
    logic [tfn_pkg::ProdW:0] absv [3];

    // Edge vectors from the second corner
    always_comb begin
        a_next.x = tfn_pkg::DiffW'(p2.x) - tfn_pkg::DiffW'(p1.x);
        a_next.y = tfn_pkg::DiffW'(p2.y) - tfn_pkg::DiffW'(p1.y);
        a_next.z = tfn_pkg::DiffW'(p2.z) - tfn_pkg::DiffW'(p1.z);
        b_next.x = tfn_pkg::DiffW'(p0.x) - tfn_pkg::DiffW'(p1.x);
        b_next.y = tfn_pkg::DiffW'(p0.y) - tfn_pkg::DiffW'(p1.y);
        b_next.z = tfn_pkg::DiffW'(p0.z) - tfn_pkg::DiffW'(p1.z);
    end

    // Six partial products of the cross product
    always_comb begin
        prod_next[0] = a_reg.y * b_reg.z;
        prod_next[1] = a_reg.z * b_reg.y;
        prod_next[2] = a_reg.z * b_reg.x;
        prod_next[3] = a_reg.x * b_reg.z;
        prod_next[4] = a_reg.x * b_reg.y;
        prod_next[5] = a_reg.y * b_reg.x;
    end

    // Cross components, split into sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c[i] = {prod_reg[2*i][tfn_pkg::ProdW-1], prod_reg[2*i]}
                 - {prod_reg[2*i+1][tfn_pkg::ProdW-1], prod_reg[2*i+1]};
            absv[i] = c[i][tfn_pkg::ProdW] ? -c[i] : c[i];
            mag_next[i] = absv[i][tfn_pkg::MagW-1:0];
            side_next.neg[i] = c[i][tfn_pkg::ProdW];
        end
        side_next.zero = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_mag   = mag_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/tfn_sqsum.sv =====
module tfn_sqsum (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  tfn_pkg::tfn_mag3_t           in_mag,
    input  tfn_pkg::tfn_side_t           in_side,
    output logic                         out_valid,
    output logic [tfn_pkg::SqW-1:0]      out_sum,
    output tfn_pkg::tfn_mag3_t           out_mag,
    output tfn_pkg::tfn_side_t           out_side
);

    localparam int H = tfn_pkg::HalfW;

    logic [2*H-1:0] hh_reg [3], hl_reg [3], ll_reg [3];
    logic [2*H-1:0] hh_next [3], hl_next [3], ll_next [3];
    logic [tfn_pkg::SqW-1:0] sq_reg [3], sq_next [3];
    logic [tfn_pkg::SqW-1:0] sum_reg, sum_next;
    tfn_pkg::tfn_mag3_t mag_reg [3];
    tfn_pkg::tfn_side_t side_reg [3];
    logic [2:0] vld_reg;

    // Split each square into 25 by 25 partial products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hh_next[i] = in_mag[i][2*H-1:H] * in_mag[i][2*H-1:H];
            hl_next[i] = in_mag[i][2*H-1:H] * in_mag[i][H-1:0];
            ll_next[i] = in_mag[i][H-1:0]   * in_mag[i][H-1:0];
        end
    end

    // Recombine each square
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = (tfn_pkg::SqW'(hh_reg[i]) << (2*H))
                       + (tfn_pkg::SqW'(hl_reg[i]) << (H+1))
                       + tfn_pkg::SqW'(ll_reg[i]);
        end
    end

    // Squared length
    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg      <= hh_next;
            hl_reg      <= hl_next;
            ll_reg      <= ll_next;
            sq_reg      <= sq_next;
            sum_reg     <= sum_next;
            mag_reg[0]  <= in_mag;
            mag_reg[1]  <= mag_reg[0];
            mag_reg[2]  <= mag_reg[1];
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_sum   = sum_reg;
    assign out_mag   = mag_reg[2];
    assign out_side  = side_reg[2];

endmodule

// ===== hdl/tfn_isqrt.sv =====
module tfn_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tfn_pkg::SqW-1:0]      in_sum,
    input  tfn_pkg::tfn_mag3_t           in_mag,
    input  tfn_pkg::tfn_side_t           in_side,
    output logic                         out_valid,
    output logic [tfn_pkg::RootW-1:0]    out_len,
    output tfn_pkg::tfn_mag3_t           out_mag,
    output tfn_pkg::tfn_side_t           out_side
);

    localparam int N  = tfn_pkg::RootW;
    localparam int RW = tfn_pkg::RemW;

    logic [RW-1:0]      rem_reg  [N];
    logic [N-1:0]       root_reg [N];
    tfn_pkg::tfn_mag3_t mag_reg  [N];
    tfn_pkg::tfn_side_t side_reg [N];
    logic [N-1:0]       vld_reg;

    // One root bit per stage, most significant first
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;
        logic [RW-1:0]      rem_prev, trial, rem_next;
        logic [N-1:0]       root_prev, root_next;
        tfn_pkg::tfn_mag3_t mag_prev;
        tfn_pkg::tfn_side_t side_prev;
        logic               vld_prev, take;

        if (k == 0) begin : g_first
            assign rem_prev  = RW'(in_sum);
            assign root_prev = '0;
            assign mag_prev  = in_mag;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign mag_prev  = mag_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        // Try the bit: subtract 2*root*2^B + 2^(2B) from the remainder
        always_comb begin
            trial     = (RW'(root_prev) << (B+1)) | (RW'(1) << (2*B));
            take      = rem_prev >= trial;
            rem_next  = take ? rem_prev - trial : rem_prev;
            root_next = root_prev | (N'(take) << B);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                mag_reg[k]  <= mag_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_len   = root_reg[N-1];
    assign out_mag   = mag_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hdl/tfn_div.sv =====
module tfn_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tfn_pkg::RootW-1:0]     in_len,
    input  tfn_pkg::tfn_mag3_t            in_mag,
    input  tfn_pkg::tfn_side_t            in_side,
    input  logic [tfn_pkg::LimW-1:0]      limit,
    output logic                          out_valid,
    output logic signed [tfn_pkg::NormW-1:0] out_x,
    output logic signed [tfn_pkg::NormW-1:0] out_y,
    output logic signed [tfn_pkg::NormW-1:0] out_z,
    output logic                          out_degenerate
);

    localparam int N  = tfn_pkg::QuotW;
    localparam int DW = tfn_pkg::DivW;
    localparam int NW = tfn_pkg::NormW;

    logic [2:0][DW-1:0]      rem_reg  [N];
    logic [2:0][N-1:0]       quo_reg  [N];
    logic [tfn_pkg::RootW-1:0] len_reg [N];
    tfn_pkg::tfn_side_t      side_reg [N];
    logic [N-1:0]            vld_reg;
    logic [2:0][NW-1:0]      norm_reg, norm_next;
    logic                    degen_reg, degen_next, out_vld_reg;
    logic [NW-1:0]           qx;

    // One quotient bit per stage for all three components
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;
        logic [2:0][DW-1:0]        rem_prev, rem_next;
        logic [2:0][N-1:0]         quo_prev, quo_next;
        logic [tfn_pkg::RootW-1:0] len_prev;
        tfn_pkg::tfn_side_t        side_prev;
        logic                      vld_prev;
        logic [DW-1:0]             dsr;

        if (k == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_prev[i] = DW'(in_mag[i]) << tfn_pkg::FracW;
                end
            end
            assign quo_prev  = '0;
            assign len_prev  = in_len;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign len_prev  = len_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        // Restoring step against the shifted length
        always_comb begin
            dsr = DW'(len_prev) << B;
            for (int i = 0; i < 3; i++) begin
                if (rem_prev[i] >= dsr) begin
                    rem_next[i] = rem_prev[i] - dsr;
                    quo_next[i] = quo_prev[i] | (N'(1) << B);
                end else begin
                    rem_next[i] = rem_prev[i];
                    quo_next[i] = quo_prev[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                len_reg[k]  <= len_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    // Apply signs, the zero-normal case and the area test
    always_comb begin
        qx = '0;
        for (int i = 0; i < 3; i++) begin
            qx = NW'(quo_reg[N-1][i]);
            if (side_reg[N-1].zero) begin
                norm_next[i] = (i == 1) ? tfn_pkg::OneQ14 : '0;
            end else begin
                norm_next[i] = side_reg[N-1].neg[i] ? (~qx + NW'(1)) : qx;
            end
        end
        degen_next = len_reg[N-1] < tfn_pkg::RootW'(limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg  <= norm_next;
            degen_reg <= degen_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign out_x          = norm_reg[0];
    assign out_y          = norm_reg[1];
    assign out_z          = norm_reg[2];
    assign out_degenerate = degen_reg;

endmodule

// ===== test/triangle_face_normal_tb.sv =====
`timescale 1ns / 100ps

module triangle_face_normal_tb;

    localparam int LatencyCycles = 73;
    localparam int StallLimit    = 20000;
    localparam int RandomItems   = 950;

    typedef struct packed {
        logic signed [tfn_pkg::CoordW-1:0] p0_x, p0_y, p0_z;
        logic signed [tfn_pkg::CoordW-1:0] p1_x, p1_y, p1_z;
        logic signed [tfn_pkg::CoordW-1:0] p2_x, p2_y, p2_z;
    } corners_t;

    typedef struct packed {
        logic signed [tfn_pkg::NormW-1:0] nx, ny, nz;
        logic                             degen;
    } face_normal_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [tfn_pkg::CoordW-1:0] s_p0_x = '0, s_p0_y = '0, s_p0_z = '0;
    logic signed [tfn_pkg::CoordW-1:0] s_p1_x = '0, s_p1_y = '0, s_p1_z = '0;
    logic signed [tfn_pkg::CoordW-1:0] s_p2_x = '0, s_p2_y = '0, s_p2_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [tfn_pkg::NormW-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tfn_pkg::LimW-1:0] cfg_twice_area_limit = '0;

    corners_t     pending_faces[$];
    face_normal_t expected_normals[$];
    logic [tfn_pkg::LimW-1:0] area_limit;
    logic [tfn_pkg::LimW-1:0] cfg_pending_value;
    bit   cfg_request = 1'b0;
    bit   cfg_done = 1'b0;
    int   error_count = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   recv_gap = 0;

    triangle_face_normal u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p0_x(s_p0_x), .s_p0_y(s_p0_y), .s_p0_z(s_p0_z),
        .s_p1_x(s_p1_x), .s_p1_y(s_p1_y), .s_p1_z(s_p1_z),
        .s_p2_x(s_p2_x), .s_p2_y(s_p2_y), .s_p2_z(s_p2_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z),
        .m_degenerate(m_degenerate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_twice_area_limit(cfg_twice_area_limit)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Truncating quotient of one cross component over the length
    function automatic logic signed [tfn_pkg::NormW-1:0] scale_axis(logic signed [63:0] c,
                                                                    logic [63:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        q = (mag << tfn_pkg::FracW) / 128'(len);
        return (c < 0) ? tfn_pkg::NormW'(-q) : tfn_pkg::NormW'(q);
    endfunction

    // Unit normal from the exact cross product and a bitwise square root
    function automatic face_normal_t face_normal(corners_t f,
                                                 logic [tfn_pkg::LimW-1:0] lim);
        logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [127:0] sum_sq, cand_sq;
        logic [63:0] root, cand;
        face_normal_t r;
        ax = 64'(f.p2_x) - 64'(f.p1_x);
        ay = 64'(f.p2_y) - 64'(f.p1_y);
        az = 64'(f.p2_z) - 64'(f.p1_z);
        bx = 64'(f.p0_x) - 64'(f.p1_x);
        by = 64'(f.p0_y) - 64'(f.p1_y);
        bz = 64'(f.p0_z) - 64'(f.p1_z);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        sum_sq = 128'($signed(cx)) * 128'($signed(cx)) + 128'($signed(cy)) * 128'($signed(cy))
               + 128'($signed(cz)) * 128'($signed(cz));
        root = '0;
        for (int b = 50; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            cand_sq = 128'(cand) * 128'(cand);
            if (cand_sq <= sum_sq) root = cand;
        end
        if (cx == 0 && cy == 0 && cz == 0) begin
            r.nx = '0;
            r.ny = tfn_pkg::OneQ14;
            r.nz = '0;
        end else begin
            r.nx = scale_axis(cx, root);
            r.ny = scale_axis(cy, root);
            r.nz = scale_axis(cz, root);
        end
        r.degen = (root < 64'(lim));
        return r;
    endfunction

    function automatic logic signed [tfn_pkg::CoordW-1:0] pick_coord(int mode);
        case (mode)
            0: return tfn_pkg::CoordW'($urandom);
            1: return tfn_pkg::CoordW'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return tfn_pkg::CoordW'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic corners_t random_face();
        corners_t f;
        int mode;
        mode = $urandom_range(0, 5);
        f.p0_x = pick_coord(mode); f.p0_y = pick_coord(mode); f.p0_z = pick_coord(mode);
        f.p1_x = pick_coord(mode); f.p1_y = pick_coord(mode); f.p1_z = pick_coord(mode);
        f.p2_x = pick_coord(mode); f.p2_y = pick_coord(mode); f.p2_z = pick_coord(mode);
        // give a share of triangles a shared x coordinate, and collapse a share onto a line
        if ($urandom_range(0, 9) == 0) f.p2_x = f.p1_x;
        if ($urandom_range(0, 14) == 0) begin
            f.p2_x = f.p1_x; f.p2_y = f.p1_y; f.p2_z = f.p1_z;
        end
        return f;
    endfunction

    function automatic corners_t make_face(int a, int b, int c, int d, int e, int g,
                                           int h, int i, int j);
        corners_t f;
        f.p0_x = tfn_pkg::CoordW'(a); f.p0_y = tfn_pkg::CoordW'(b);
        f.p0_z = tfn_pkg::CoordW'(c);
        f.p1_x = tfn_pkg::CoordW'(d); f.p1_y = tfn_pkg::CoordW'(e);
        f.p1_z = tfn_pkg::CoordW'(g);
        f.p2_x = tfn_pkg::CoordW'(h); f.p2_y = tfn_pkg::CoordW'(i);
        f.p2_z = tfn_pkg::CoordW'(j);
        return f;
    endfunction

    // Queue one item for the driver
    task automatic add_face(corners_t f);
        pending_faces = {pending_faces, f};
    endtask

    // Write the limit while the block is idle
    task automatic write_limit(logic [tfn_pkg::LimW-1:0] value);
        while (pending_faces.size() != 0 || s_valid || expected_normals.size() != 0)
            @(negedge aclk);
        repeat (LatencyCycles + 4) @(posedge aclk);
        cfg_pending_value = value;
        cfg_request = 1'b1;
        wait (cfg_done);
        cfg_request = 1'b0;
        @(posedge aclk);
        cfg_done = 1'b0;
    endtask

    // Configuration channel
    always @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            area_limit <= cfg_twice_area_limit;
            cfg_valid <= 1'b0;
            cfg_done <= 1'b1;
        end else if (cfg_request && !cfg_valid && !cfg_done) begin
            cfg_valid <= 1'b1;
            cfg_twice_area_limit <= cfg_pending_value;
        end
    end

    // Driver: hold each item until accepted, then wait a random gap
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_normals = {expected_normals, face_normal({s_p0_x, s_p0_y, s_p0_z,
                    s_p1_x, s_p1_y, s_p1_z, s_p2_x, s_p2_y, s_p2_z}, area_limit)};
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_faces.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    corners_t f;
                    f = pending_faces.pop_front();
                    s_valid <= 1'b1;
                    {s_p0_x, s_p0_y, s_p0_z, s_p1_x, s_p1_y, s_p1_z,
                     s_p2_x, s_p2_y, s_p2_z} <= f;
                    send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected result %0d %0d %0d %0b", $time,
                             m_normal_x, m_normal_y, m_normal_z, m_degenerate);
                    error_count++;
                end else begin
                    face_normal_t e;
                    e = expected_normals.pop_front();
                    if (e.nx !== m_normal_x || e.ny !== m_normal_y ||
                        e.nz !== m_normal_z || e.degen !== m_degenerate) begin
                        $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $time, e.nx, e.ny, e.nz, e.degen, m_normal_x,
                                 m_normal_y, m_normal_z, m_degenerate);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
            // watchdog
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("triangle_face_normal_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [tfn_pkg::LimW-1:0] limits[5];
        area_limit = tfn_pkg::LimitReset;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, a flat triangle, a collapsed one, axis normals
        add_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_face(make_face(4096, 0, 0, 0, 0, 0, 0, 4096, 0));
        add_face(make_face(0, 4096, 0, 0, 0, 0, 4096, 0, 0));
        add_face(make_face(0, 0, 1, 0, 0, 0, 1, 0, 0));
        add_face(make_face(0, 1, 0, 0, 0, 0, 0, 0, 1));
        add_face(make_face(1, 2, 3, 2, 4, 6, 3, 6, 9));
        add_face(make_face(8388607, 8388607, 8388607, -8388608, -8388608,
                           -8388608, 8388607, -8388608, 8388607));
        add_face(make_face(-8388608, 8388607, -8388608, 8388607,
                           -8388608, 8388607, -8388608, -8388608, 8388607));
        add_face(make_face(8388607, 0, 0, -8388608, 0, 0, 0, 8388607, 0));
        add_face(make_face(-1, -1, -1, 0, 0, 0, 1, -1, 0));
        add_face(make_face(5, 7, 11, 5, 7, 11, 5, 7, 11));
        add_face(make_face(0, 0, 0, 3, 0, 0, 0, 0, 3));

        // Random phases under several limits, extremes among them
        limits[0] = '0;
        limits[1] = {tfn_pkg::LimW{1'b1}};
        limits[2] = tfn_pkg::LimW'(5);
        limits[3] = tfn_pkg::LimW'(64'd1 << 36);
        limits[4] = tfn_pkg::LimW'({$urandom, $urandom});
        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_limit(limits[p - 1]);
            for (int k = 0; k < RandomItems / 6; k++)
                add_face(random_face());
        end

        while (pending_faces.size() != 0 || s_valid || expected_normals.size() != 0)
            @(negedge aclk);
        repeat (LatencyCycles + 10) @(posedge aclk);
        if (error_count == 0 && expected_normals.size() == 0)
            $display("triangle_face_normal_tb: clean");
        else
            $display("triangle_face_normal_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tfn_pkg.sv
hdl/tfn_cross.sv
hdl/tfn_sqsum.sv
hdl/tfn_isqrt.sv
hdl/tfn_div.sv
hdl/triangle_face_normal.sv
test/triangle_face_normal_tb.sv
